// ===== hdl/idsp_pkg.sv =====
// Shared types and constants of the ISO date stream parser.
`default_nettype none
package idsp_pkg;

   localparam int CHAR_W       = 8;
   localparam int OPT_W        = 4;
   localparam int YEAR_W       = 25;
   localparam int MONTH_W      = 4;
   localparam int DAY_W        = 5;
   localparam int CHARS_W      = 4;
   localparam int FIELD_ACC_W  = 7;
   localparam int REQ_DATA_W   = 8;
   localparam int RSP_DATA_W   = 40;
   localparam int QUEUE_DEPTH  = 2;
   localparam int NORMAL_YEAR_DIGITS = 4;
   localparam int MONTH_MAX    = 12;
   localparam int DAY_MAX      = 31;
   localparam logic [CHARS_W-1:0] CHARS_SAT = 4'd15;

   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

   localparam int OPT_EXP   = 0;
   localparam int OPT_ALT   = 1;
   localparam int OPT_NOSEP = 2;
   localparam int OPT_TERM  = 3;

   typedef struct packed {
      logic       start;
      logic       digit;
      logic [3:0] dval;
      logic       plus;
      logic       minus;
      logic       slash;
      logic       dot;
      logic       nul;
   } item_type;

   typedef enum logic [1:0] {
      SEP_NONE  = 2'd0,
      SEP_DASH  = 2'd1,
      SEP_SLASH = 2'd2,
      SEP_DOT   = 2'd3
   } sep_type;

   typedef enum logic [10:0] {
      PH_IDLE   = 11'b000_0000_0001,
      PH_YSTART = 11'b000_0000_0010,
      PH_YFIRST = 11'b000_0000_0100,
      PH_YMORE  = 11'b000_0000_1000,
      PH_SEP1   = 11'b000_0001_0000,
      PH_M1     = 11'b000_0010_0000,
      PH_M2     = 11'b000_0100_0000,
      PH_SEP2   = 11'b000_1000_0000,
      PH_D1     = 11'b001_0000_0000,
      PH_D2     = 11'b010_0000_0000,
      PH_TERM   = 11'b100_0000_0000
   } phase_type;

endpackage
`default_nettype wire

// ===== hdl/iso_date_stream_parser_unit.sv =====
// Top level of the streaming ISO 8601 calendar date parser.
// One character is taken per transfer on the req_ stream and every cycle can carry a new
// transfer while the character queue is not full; a start flag in req_tuser opens a string
// and, with OPT_TERM set, byte 0 ends it. Each string yields at most one result on the rsp_
// stream, at success or at the first bad character; one cut off by a new start yields none.
// A character passes the two-entry character queue, then the parser step loads the result
// register; the state update with a multiply by ten sets the rate of one character per cycle
// while no result waits untaken, and a waiting result holds the queue. Options must be written
// through the csr_ channel while the stream is quiet; the block does not enforce this.
`default_nettype none
module iso_date_stream_parser_unit #(
   parameter int MAX_YEAR_DIGITS = 7
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_byte
   input  wire logic        req_tuser,   // [0] string_start
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [24:0] year_value, [28:25] month_value,
                                         // [33:29] day_value, [37:34] chars_used, zero fill
   output logic             rsp_tuser,   // [0] parse_ok
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [3:0]  csr_data     // [3:0] option_bits
);

   logic [idsp_pkg::OPT_W-1:0]   option_ff, option_in;
   idsp_pkg::item_type           front_item;
   idsp_pkg::item_type           head_item;
   logic                         q_full;
   logic                         q_not_empty;
   logic                         q_pop;
   logic [idsp_pkg::YEAR_W-1:0]  year_value;
   logic [idsp_pkg::MONTH_W-1:0] month_value;
   logic [idsp_pkg::DAY_W-1:0]   day_value;
   logic [idsp_pkg::CHARS_W-1:0] chars_used;

   assign csr_ready = 1'b1;
   assign option_in = (csr_valid && csr_ready) ? csr_data : option_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         option_ff <= '0;
      end else begin
         option_ff <= option_in;
      end
   end

   assign req_tready = !q_full;

   idsp_front u_front (
      .char_byte    (req_tdata),
      .string_start (req_tuser),
      .item         (front_item)
   );

   idsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid && req_tready),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_item (head_item)
   );

   idsp_back #(
      .MAX_YEAR_DIGITS (MAX_YEAR_DIGITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .option_bits (option_ff),
      .item_valid  (q_not_empty),
      .item        (head_item),
      .item_pop    (q_pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .parse_ok    (rsp_tuser),
      .year_value  (year_value),
      .month_value (month_value),
      .day_value   (day_value),
      .chars_used  (chars_used)
   );

   assign rsp_tdata = {2'b00, chars_used, day_value, month_value, year_value};

endmodule
`default_nettype wire

// ===== hdl/idsp_front.sv =====
// Front end: classifies each incoming character before it is queued.
`default_nettype none
module idsp_front (
   input  wire logic [idsp_pkg::CHAR_W-1:0] char_byte,
   input  wire logic                        string_start,
   output idsp_pkg::item_type               item
);

   always_comb begin
      item.start = string_start;
      item.digit = (char_byte >= idsp_pkg::CH_ZERO) && (char_byte <= idsp_pkg::CH_NINE);
      item.dval  = 4'(char_byte - idsp_pkg::CH_ZERO);
      item.plus  = (char_byte == idsp_pkg::CH_PLUS);
      item.minus = (char_byte == idsp_pkg::CH_MINUS);
      item.slash = (char_byte == idsp_pkg::CH_SLASH);
      item.dot   = (char_byte == idsp_pkg::CH_DOT);
      item.nul   = (char_byte == idsp_pkg::CH_NUL);
   end

endmodule
`default_nettype wire

// ===== hdl/idsp_queue.sv =====
// Short queue of classified characters between front and back end.
`default_nettype none
module idsp_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire idsp_pkg::item_type push_item,
   output logic                    full,
   input  wire logic               pop,
   output logic                    not_empty,
   output idsp_pkg::item_type      head_item
);

   localparam int PTR_W = $clog2(idsp_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(idsp_pkg::QUEUE_DEPTH + 1);

   idsp_pkg::item_type entry_ff [idsp_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in;
   logic [PTR_W-1:0] rptr_ff, rptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(idsp_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = entry_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == PTR_W'(idsp_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == PTR_W'(idsp_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/idsp_back.sv =====
// Back end: date parsing state machine and result register.
`default_nettype none
module idsp_back #(
   parameter int MAX_YEAR_DIGITS = 7
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [idsp_pkg::OPT_W-1:0]    option_bits,
   input  wire logic                          item_valid,
   input  wire idsp_pkg::item_type            item,
   output logic                               item_pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               parse_ok,
   output logic [idsp_pkg::YEAR_W-1:0]        year_value,
   output logic [idsp_pkg::MONTH_W-1:0]       month_value,
   output logic [idsp_pkg::DAY_W-1:0]         day_value,
   output logic [idsp_pkg::CHARS_W-1:0]       chars_used
);

   localparam int YACC_W = $clog2(10 ** MAX_YEAR_DIGITS);
   localparam int YEXT_W = (YACC_W > idsp_pkg::YEAR_W) ? YACC_W : idsp_pkg::YEAR_W;
   localparam int YCNT_W = $clog2(MAX_YEAR_DIGITS + 1);
   localparam int FW     = idsp_pkg::FIELD_ACC_W;

   idsp_pkg::phase_type            phase_ff, phase_in;
   logic [YACC_W-1:0]              yacc_ff, yacc_in;
   logic [YCNT_W-1:0]              ycnt_ff, ycnt_in;
   logic                           yneg_ff, yneg_in;
   idsp_pkg::sep_type              sep_ff, sep_in;
   logic [FW-1:0]                  macc_ff, macc_in;
   logic [FW-1:0]                  dacc_ff, dacc_in;
   logic [idsp_pkg::CHARS_W-1:0]   ccnt_ff, ccnt_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           ok_ff, ok_in;
   logic [idsp_pkg::YEAR_W-1:0]    year_ff, year_in;
   logic [idsp_pkg::MONTH_W-1:0]   month_ff, month_in;
   logic [idsp_pkg::DAY_W-1:0]     day_ff, day_in;
   logic [idsp_pkg::CHARS_W-1:0]   chars_ff, chars_in;

   logic                           done;
   logic                           emit;
   logic                           good;
   logic                           exp_mode;
   logic [FW-1:0]                  dwide;
   logic [YEXT_W-1:0]              yext;
   logic [YEXT_W-1:0]              ysigned;

   assign exp_mode = option_bits[idsp_pkg::OPT_EXP];
   assign dwide    = FW'(item.dval);
   assign item_pop = item_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      phase_in = phase_ff;
      yacc_in  = yacc_ff;
      ycnt_in  = ycnt_ff;
      yneg_in  = yneg_ff;
      sep_in   = sep_ff;
      macc_in  = macc_ff;
      dacc_in  = dacc_ff;
      ccnt_in  = ccnt_ff;
      done     = 1'b0;
      emit     = 1'b0;
      good     = 1'b0;

      if (item.start) begin
         yacc_in  = '0;
         ycnt_in  = '0;
         yneg_in  = 1'b0;
         sep_in   = idsp_pkg::SEP_NONE;
         macc_in  = '0;
         dacc_in  = '0;
         ccnt_in  = '0;
         phase_in = idsp_pkg::PH_YSTART;
      end

      if (phase_in == idsp_pkg::PH_IDLE) begin
         done = 1'b1;
      end

      if (!done && phase_in == idsp_pkg::PH_YSTART) begin
         phase_in = idsp_pkg::PH_YFIRST;
         if (exp_mode && (item.plus || item.minus)) begin
            yneg_in = item.minus;
            ccnt_in = (ccnt_in == idsp_pkg::CHARS_SAT) ? ccnt_in : ccnt_in + 1'b1;
            done    = 1'b1;
         end
      end

      if (!done && phase_in == idsp_pkg::PH_YFIRST) begin
         done = 1'b1;
         if (!item.digit) begin
            emit = 1'b1;
         end else begin
            yacc_in  = YACC_W'(item.dval);
            ycnt_in  = YCNT_W'(1);
            ccnt_in  = (ccnt_in == idsp_pkg::CHARS_SAT) ? ccnt_in : ccnt_in + 1'b1;
            phase_in = idsp_pkg::PH_YMORE;
         end
      end

      if (!done && phase_in == idsp_pkg::PH_YMORE) begin
         if (exp_mode) begin
            if (item.digit) begin
               done = 1'b1;
               if (ycnt_in >= YCNT_W'(MAX_YEAR_DIGITS)) begin
                  emit = 1'b1;
               end else begin
                  yacc_in = (yacc_in << 3) + (yacc_in << 1) + YACC_W'(item.dval);
                  ycnt_in = ycnt_in + 1'b1;
                  ccnt_in = (ccnt_in == idsp_pkg::CHARS_SAT) ? ccnt_in : ccnt_in + 1'b1;
               end
            end else begin
               phase_in = idsp_pkg::PH_SEP1;
            end
         end else if (ycnt_in < YCNT_W'(idsp_pkg::NORMAL_YEAR_DIGITS)) begin
            done = 1'b1;
            if (!item.digit) begin
               emit = 1'b1;
            end else begin
               yacc_in = (yacc_in << 3) + (yacc_in << 1) + YACC_W'(item.dval);
               ycnt_in = ycnt_in + 1'b1;
               ccnt_in = (ccnt_in == idsp_pkg::CHARS_SAT) ? ccnt_in : ccnt_in + 1'b1;
            end
         end else begin
            phase_in = idsp_pkg::PH_SEP1;
         end
      end

      if (!done && phase_in == idsp_pkg::PH_SEP1) begin
         if (item.slash || item.dot) begin
            done = 1'b1;
            if (!option_bits[idsp_pkg::OPT_ALT]) begin
               emit = 1'b1;
            end else begin
               sep_in   = item.slash ? idsp_pkg::SEP_SLASH : idsp_pkg::SEP_DOT;
               ccnt_in  = (ccnt_in == idsp_pkg::CHARS_SAT) ? ccnt_in : ccnt_in + 1'b1;
               phase_in = idsp_pkg::PH_M1;
            end
         end else if (item.minus) begin
            done     = 1'b1;
            sep_in   = idsp_pkg::SEP_DASH;
            ccnt_in  = (ccnt_in == idsp_pkg::CHARS_SAT) ? ccnt_in : ccnt_in + 1'b1;
            phase_in = idsp_pkg::PH_M1;
         end else if (!option_bits[idsp_pkg::OPT_NOSEP]) begin
            done = 1'b1;
            emit = 1'b1;
         end else begin
            sep_in   = idsp_pkg::SEP_NONE;
            phase_in = idsp_pkg::PH_M1;
         end
      end

      if (!done) begin
         case (phase_in)
            idsp_pkg::PH_M1: begin
               if (!item.digit) begin
                  emit = 1'b1;
               end else begin
                  macc_in  = (dwide << 3) + (dwide << 1);
                  ccnt_in  = (ccnt_in == idsp_pkg::CHARS_SAT) ? ccnt_in : ccnt_in + 1'b1;
                  phase_in = idsp_pkg::PH_M2;
               end
            end
            idsp_pkg::PH_M2: begin
               macc_in = macc_in + dwide;
               if (!item.digit || macc_in < FW'(1) || macc_in > FW'(idsp_pkg::MONTH_MAX)) begin
                  emit = 1'b1;
               end else begin
                  ccnt_in  = (ccnt_in == idsp_pkg::CHARS_SAT) ? ccnt_in : ccnt_in + 1'b1;
                  phase_in = (sep_in != idsp_pkg::SEP_NONE) ? idsp_pkg::PH_SEP2
                                                            : idsp_pkg::PH_D1;
               end
            end
            idsp_pkg::PH_SEP2: begin
               if ((sep_in == idsp_pkg::SEP_DASH && item.minus) ||
                   (sep_in == idsp_pkg::SEP_SLASH && item.slash) ||
                   (sep_in == idsp_pkg::SEP_DOT && item.dot)) begin
                  ccnt_in  = (ccnt_in == idsp_pkg::CHARS_SAT) ? ccnt_in : ccnt_in + 1'b1;
                  phase_in = idsp_pkg::PH_D1;
               end else begin
                  emit = 1'b1;
               end
            end
            idsp_pkg::PH_D1: begin
               if (!item.digit) begin
                  emit = 1'b1;
               end else begin
                  dacc_in  = (dwide << 3) + (dwide << 1);
                  ccnt_in  = (ccnt_in == idsp_pkg::CHARS_SAT) ? ccnt_in : ccnt_in + 1'b1;
                  phase_in = idsp_pkg::PH_D2;
               end
            end
            idsp_pkg::PH_D2: begin
               dacc_in = dacc_in + dwide;
               if (!item.digit || dacc_in < FW'(1) || dacc_in > FW'(idsp_pkg::DAY_MAX)) begin
                  emit = 1'b1;
               end else begin
                  ccnt_in = (ccnt_in == idsp_pkg::CHARS_SAT) ? ccnt_in : ccnt_in + 1'b1;
                  if (option_bits[idsp_pkg::OPT_TERM]) begin
                     phase_in = idsp_pkg::PH_TERM;
                  end else begin
                     emit = 1'b1;
                     good = 1'b1;
                  end
               end
            end
            idsp_pkg::PH_TERM: begin
               emit = 1'b1;
               good = item.nul;
            end
            default: begin
               phase_in = idsp_pkg::PH_IDLE;
            end
         endcase
      end

      if (emit) begin
         phase_in = idsp_pkg::PH_IDLE;
      end
   end

   assign yext    = YEXT_W'(yacc_in);
   assign ysigned = yneg_in ? (YEXT_W'(0) - yext) : yext;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      ok_in        = ok_ff;
      year_in      = year_ff;
      month_in     = month_ff;
      day_in       = day_ff;
      chars_in     = chars_ff;
      if (item_pop) begin
         rsp_valid_in = emit;
         if (emit) begin
            ok_in    = good;
            year_in  = good ? ysigned[idsp_pkg::YEAR_W-1:0] : '0;
            month_in = good ? macc_in[idsp_pkg::MONTH_W-1:0] : '0;
            day_in   = good ? dacc_in[idsp_pkg::DAY_W-1:0] : '0;
            chars_in = good ? ccnt_in : '0;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= idsp_pkg::PH_IDLE;
         yacc_ff      <= '0;
         ycnt_ff      <= '0;
         yneg_ff      <= 1'b0;
         sep_ff       <= idsp_pkg::SEP_NONE;
         macc_ff      <= '0;
         dacc_ff      <= '0;
         ccnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (item_pop) begin
            phase_ff <= phase_in;
            yacc_ff  <= yacc_in;
            ycnt_ff  <= ycnt_in;
            yneg_ff  <= yneg_in;
            sep_ff   <= sep_in;
            macc_ff  <= macc_in;
            dacc_ff  <= dacc_in;
            ccnt_ff  <= ccnt_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff    <= ok_in;
      year_ff  <= year_in;
      month_ff <= month_in;
      day_ff   <= day_in;
      chars_ff <= chars_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign parse_ok    = ok_ff;
   assign year_value  = year_ff;
   assign month_value = month_ff;
   assign day_value   = day_ff;
   assign chars_used  = chars_ff;

endmodule
`default_nettype wire

// ===== test/iso_date_stream_parser_unit_test.sv =====
// Self-checking stream testbench for the ISO 8601 date parser, with a scoreboard class.
`timescale 1ns / 1ps
module iso_date_stream_parser_unit_test;

   localparam int YEAR_DIGITS_MAX = 7;
   localparam int RANDOM_ITEMS    = 1820;
   localparam int OPT_PHASES      = 20;
   localparam int PHASE_ITEMS     = RANDOM_ITEMS / OPT_PHASES;
   localparam int SETTLE_CYCLES   = 8;
   localparam int QUIET_LIMIT     = 1000;

   logic                                clock      = 1'b0;
   logic                                reset      = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [idsp_pkg::REQ_DATA_W-1:0]     req_tdata  = '0;
   logic                                req_tuser  = 1'b0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [idsp_pkg::RSP_DATA_W-1:0]     rsp_tdata;
   logic                                rsp_tuser;
   logic                                csr_valid  = 1'b0;
   logic                                csr_ready;
   logic [idsp_pkg::OPT_W-1:0]          csr_data   = '0;

   typedef struct packed {
      logic                          ok;
      logic [idsp_pkg::YEAR_W-1:0]   year;
      logic [idsp_pkg::MONTH_W-1:0]  month;
      logic [idsp_pkg::DAY_W-1:0]    day;
      logic [idsp_pkg::CHARS_W-1:0]  used;
   } date_result_type;

   function automatic logic [idsp_pkg::CHAR_W-1:0] sep_byte(idsp_pkg::sep_type kind);
      case (kind)
         idsp_pkg::SEP_DASH:  return idsp_pkg::CH_MINUS;
         idsp_pkg::SEP_SLASH: return idsp_pkg::CH_SLASH;
         idsp_pkg::SEP_DOT:   return idsp_pkg::CH_DOT;
         default:             return idsp_pkg::CH_NUL;
      endcase
   endfunction

   class date_scoreboard;
      logic [idsp_pkg::OPT_W-1:0]       opts;
      idsp_pkg::phase_type              phase;
      logic [23:0]                      year_acc;
      int unsigned                      year_digits;
      bit                               year_neg;
      idsp_pkg::sep_type                sep;
      logic [idsp_pkg::FIELD_ACC_W-1:0] month_acc;
      logic [idsp_pkg::FIELD_ACC_W-1:0] day_acc;
      logic [idsp_pkg::CHARS_W-1:0]     used;
      date_result_type                  waiting[$];
      int                               errors;

      function new();
         opts = '0;
         phase = idsp_pkg::PH_IDLE;
         errors = 0;
      endfunction

      function void take_char();
         if (used != idsp_pkg::CHARS_SAT) used++;
      endfunction

      function void give_fail();
         waiting.push_back('0);
         phase = idsp_pkg::PH_IDLE;
      endfunction

      function void give_ok();
         date_result_type r;
         r.ok    = 1'b1;
         r.year  = year_neg ? -{1'b0, year_acc} : {1'b0, year_acc};
         r.month = month_acc[idsp_pkg::MONTH_W-1:0];
         r.day   = day_acc[idsp_pkg::DAY_W-1:0];
         r.used  = used;
         waiting.push_back(r);
         phase = idsp_pkg::PH_IDLE;
      endfunction

      function void note_char(logic [idsp_pkg::CHAR_W-1:0] c, logic start);
         logic [3:0] d;
         bit         dig;
         bit         expd;
         d = c[3:0];
         dig = (c >= idsp_pkg::CH_ZERO) && (c <= idsp_pkg::CH_NINE);
         expd = opts[idsp_pkg::OPT_EXP];
         if (start) begin
            year_acc = '0;
            year_digits = 0;
            year_neg = 1'b0;
            sep = idsp_pkg::SEP_NONE;
            month_acc = '0;
            day_acc = '0;
            used = '0;
            phase = idsp_pkg::PH_YSTART;
         end
         if (phase == idsp_pkg::PH_IDLE) return;
         if (phase == idsp_pkg::PH_YSTART) begin
            phase = idsp_pkg::PH_YFIRST;
            if (expd && (c == idsp_pkg::CH_PLUS || c == idsp_pkg::CH_MINUS)) begin
               year_neg = (c == idsp_pkg::CH_MINUS);
               take_char();
               return;
            end
         end
         if (phase == idsp_pkg::PH_YFIRST) begin
            if (!dig) begin
               give_fail();
               return;
            end
            year_acc = 24'(d);
            year_digits = 1;
            take_char();
            phase = idsp_pkg::PH_YMORE;
            return;
         end
         if (phase == idsp_pkg::PH_YMORE) begin
            if (expd) begin
               if (dig) begin
                  if (year_digits >= YEAR_DIGITS_MAX) begin
                     give_fail();
                     return;
                  end
                  year_acc = year_acc * 24'd10 + 24'(d);
                  year_digits++;
                  take_char();
                  return;
               end
               phase = idsp_pkg::PH_SEP1;
            end else if (year_digits < idsp_pkg::NORMAL_YEAR_DIGITS) begin
               if (!dig) begin
                  give_fail();
                  return;
               end
               year_acc = year_acc * 24'd10 + 24'(d);
               year_digits++;
               take_char();
               return;
            end else begin
               phase = idsp_pkg::PH_SEP1;
            end
         end
         if (phase == idsp_pkg::PH_SEP1) begin
            if (c == idsp_pkg::CH_SLASH || c == idsp_pkg::CH_DOT) begin
               if (!opts[idsp_pkg::OPT_ALT]) begin
                  give_fail();
                  return;
               end
               sep = (c == idsp_pkg::CH_SLASH) ? idsp_pkg::SEP_SLASH : idsp_pkg::SEP_DOT;
               take_char();
               phase = idsp_pkg::PH_M1;
               return;
            end
            if (c == idsp_pkg::CH_MINUS) begin
               sep = idsp_pkg::SEP_DASH;
               take_char();
               phase = idsp_pkg::PH_M1;
               return;
            end
            if (!opts[idsp_pkg::OPT_NOSEP]) begin
               give_fail();
               return;
            end
            sep = idsp_pkg::SEP_NONE;
            phase = idsp_pkg::PH_M1;
         end
         case (phase)
            idsp_pkg::PH_M1: begin
               if (!dig) begin
                  give_fail();
                  return;
               end
               month_acc = idsp_pkg::FIELD_ACC_W'(d * 10);
               take_char();
               phase = idsp_pkg::PH_M2;
            end
            idsp_pkg::PH_M2: begin
               if (!dig) begin
                  give_fail();
                  return;
               end
               month_acc = month_acc + d;
               if (month_acc < 1 || month_acc > idsp_pkg::MONTH_MAX) begin
                  give_fail();
                  return;
               end
               take_char();
               phase = (sep != idsp_pkg::SEP_NONE) ? idsp_pkg::PH_SEP2 : idsp_pkg::PH_D1;
            end
            idsp_pkg::PH_SEP2: begin
               if (c != sep_byte(sep)) begin
                  give_fail();
                  return;
               end
               take_char();
               phase = idsp_pkg::PH_D1;
            end
            idsp_pkg::PH_D1: begin
               if (!dig) begin
                  give_fail();
                  return;
               end
               day_acc = idsp_pkg::FIELD_ACC_W'(d * 10);
               take_char();
               phase = idsp_pkg::PH_D2;
            end
            idsp_pkg::PH_D2: begin
               if (!dig) begin
                  give_fail();
                  return;
               end
               day_acc = day_acc + d;
               if (day_acc < 1 || day_acc > idsp_pkg::DAY_MAX) begin
                  give_fail();
                  return;
               end
               take_char();
               if (opts[idsp_pkg::OPT_TERM]) phase = idsp_pkg::PH_TERM;
               else give_ok();
            end
            idsp_pkg::PH_TERM: begin
               if (c != idsp_pkg::CH_NUL) give_fail();
               else give_ok();
            end
            default: phase = idsp_pkg::PH_IDLE;
         endcase
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(logic ok, logic [idsp_pkg::RSP_DATA_W-1:0] data);
         date_result_type want;
         if (waiting.size() == 0) begin
            $error("unexpected result transfer: tuser %0b tdata %h", ok, data);
            errors++;
            return;
         end
         want = waiting.pop_front();
         compare_field("parse_ok", 32'(want.ok), 32'(ok));
         compare_field("year_value", 32'(want.year), 32'(data[idsp_pkg::YEAR_W-1:0]));
         compare_field("month_value", 32'(want.month),
                       32'(data[idsp_pkg::YEAR_W +: idsp_pkg::MONTH_W]));
         compare_field("day_value", 32'(want.day),
                       32'(data[idsp_pkg::YEAR_W+idsp_pkg::MONTH_W +: idsp_pkg::DAY_W]));
         compare_field("chars_used", 32'(want.used),
                       32'(data[idsp_pkg::YEAR_W+idsp_pkg::MONTH_W+idsp_pkg::DAY_W +:
                                idsp_pkg::CHARS_W]));
      endfunction
   endclass

   date_scoreboard             sb;
   logic [idsp_pkg::OPT_W-1:0] cur_opts;
   logic [8:0]                 pending_chars[$];
   bit                         send_idle;
   bit                         recv_idle;
   int                         rsp_hold;
   int                         quiet_cycles;

   iso_date_stream_parser_unit #(
      .MAX_YEAR_DIGITS(YEAR_DIGITS_MAX)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int pick_gap_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
      return $urandom_range(1, 3);
   endfunction

   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_tready <= 1'b1;
         if (recv_idle && $urandom_range(0, 3) == 0) rsp_hold = pick_gap_len();
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.opts = csr_data;
         if (req_tvalid && req_tready) sb.note_char(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tuser, rsp_tdata);
         if ((csr_valid && csr_ready) || (req_tvalid && req_tready) ||
             (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   task automatic send_char(input logic [idsp_pkg::CHAR_W-1:0] c, input logic start);
      int gap;
      gap = (send_idle && $urandom_range(0, 3) == 0) ? pick_gap_len() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_text(input string s, input bit with_nul);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == 0);
      if (with_nul) send_char(idsp_pkg::CH_NUL, 1'b0);
   endtask

   // hold the stream until every result is in and the pipeline is empty
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.waiting.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_options(input logic [idsp_pkg::OPT_W-1:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_opts = value;
   endtask

   // mostly well-formed dates with random content, some broken or pure noise
   function automatic void make_string();
      logic [idsp_pkg::CHAR_W-1:0] s[$];
      int unsigned                 ndig;
      int unsigned                 fill_mode;
      int unsigned                 mon;
      int unsigned                 dy;
      int unsigned                 cut;
      int unsigned                 r;
      idsp_pkg::sep_type           sep1;
      idsp_pkg::sep_type           sep2;
      if ($urandom_range(0, 15) == 0) begin
         repeat ($urandom_range(1, 12)) s.push_back(idsp_pkg::CHAR_W'($urandom_range(0, 255)));
      end else begin
         if (cur_opts[idsp_pkg::OPT_EXP]) begin
            r = $urandom_range(0, 3);
            if (r == 0) s.push_back(idsp_pkg::CH_PLUS);
            if (r == 1) s.push_back(idsp_pkg::CH_MINUS);
            ndig = ($urandom_range(0, 9) == 0) ? YEAR_DIGITS_MAX + 1
                                                 : $urandom_range(1, YEAR_DIGITS_MAX);
         end else begin
            if ($urandom_range(0, 19) == 0) s.push_back(idsp_pkg::CH_PLUS);
            ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 5)
                                                 : idsp_pkg::NORMAL_YEAR_DIGITS;
         end
         fill_mode = $urandom_range(0, 7);
         repeat (ndig) begin
            if (fill_mode == 0) s.push_back(idsp_pkg::CH_NINE);
            else if (fill_mode == 1) s.push_back(idsp_pkg::CH_ZERO);
            else s.push_back(idsp_pkg::CH_ZERO + idsp_pkg::CHAR_W'($urandom_range(0, 9)));
         end
         sep1 = idsp_pkg::sep_type'($urandom_range(0, 3));
         if (sep1 == idsp_pkg::SEP_NONE && !cur_opts[idsp_pkg::OPT_NOSEP] &&
             $urandom_range(0, 3) != 0)
            sep1 = idsp_pkg::SEP_DASH;
         if ((sep1 == idsp_pkg::SEP_SLASH || sep1 == idsp_pkg::SEP_DOT) &&
             !cur_opts[idsp_pkg::OPT_ALT] && $urandom_range(0, 3) != 0)
            sep1 = idsp_pkg::SEP_DASH;
         sep2 = ($urandom_range(0, 9) == 0) ? idsp_pkg::sep_type'($urandom_range(0, 3)) : sep1;
         mon = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 12) : $urandom_range(0, 99);
         dy  = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 31) : $urandom_range(0, 99);
         if (sep1 != idsp_pkg::SEP_NONE) s.push_back(sep_byte(sep1));
         s.push_back(idsp_pkg::CH_ZERO + idsp_pkg::CHAR_W'(mon / 10));
         s.push_back(idsp_pkg::CH_ZERO + idsp_pkg::CHAR_W'(mon % 10));
         if (sep2 != idsp_pkg::SEP_NONE) s.push_back(sep_byte(sep2));
         s.push_back(idsp_pkg::CH_ZERO + idsp_pkg::CHAR_W'(dy / 10));
         s.push_back(idsp_pkg::CH_ZERO + idsp_pkg::CHAR_W'(dy % 10));
         r = $urandom_range(0, 9);
         if (r < 7) s.push_back(idsp_pkg::CH_NUL);
         else if (r == 7) s.push_back(idsp_pkg::CHAR_W'($urandom_range(1, 255)));
         if ($urandom_range(0, 11) == 0)
            s[$urandom_range(0, s.size() - 1)] = idsp_pkg::CHAR_W'($urandom_range(0, 255));
         if ($urandom_range(0, 19) == 0) begin
            cut = $urandom_range(1, s.size());
            while (s.size() > cut) void'(s.pop_back());
         end
      end
      if ($urandom_range(0, 9) == 0)
         repeat ($urandom_range(1, 3)) s.push_back(idsp_pkg::CHAR_W'($urandom_range(0, 255)));
      foreach (s[i]) pending_chars.push_back({i == 0, s[i]});
   endfunction

   initial begin
      logic [8:0]                 queued;
      logic [idsp_pkg::OPT_W-1:0] phase_opts;
      sb = new();
      cur_opts = '0;
      send_idle = 1'b0;
      recv_idle = 1'b0;
      rsp_hold = 0;
      quiet_cycles = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // options at reset value
      send_text("2024-12-31", 1'b0);
      send_text("2024/01-01", 1'b1);
      send_text("2024-0", 1'b0);
      send_text("+123", 1'b1);
      send_char(8'hFF, 1'b0);
      write_options(4'hF);
      send_text("-9999999.12.31", 1'b1);
      send_text("+0/01/01", 1'b1);
      send_text("12345678", 1'b1);
      send_text("2024-01.01", 1'b1);
      send_text("1999", 1'b1);
      write_options(4'h4);
      send_text("00010101", 1'b0);
      send_text("2024-13-01", 1'b0);
      send_text("2024-00-10", 1'b0);
      write_options(4'h8);
      send_text("2024-01-32", 1'b1);
      send_text("2024-01-01x", 1'b0);
      send_text("2024-", 1'b1);

      for (int p = 0; p < OPT_PHASES; p++) begin
         if (p == 0) phase_opts = 4'hF;
         else if (p == 1) phase_opts = 4'h0;
         else if (p < 16) phase_opts = idsp_pkg::OPT_W'(p - 1);
         else phase_opts = idsp_pkg::OPT_W'($urandom_range(0, 15));
         // an unfinished string carries over into the new option setting
         write_options(phase_opts);
         send_idle = $urandom_range(0, 3) != 0;
         recv_idle = $urandom_range(0, 3) != 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (pending_chars.size() == 0) make_string();
            queued = pending_chars.pop_front();
            send_char(queued[7:0], queued[8]);
         end
      end

      settle();
      if (sb.errors == 0 && sb.waiting.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/idsp_pkg.sv
hdl/idsp_front.sv
hdl/idsp_queue.sv
hdl/idsp_back.sv
hdl/iso_date_stream_parser_unit.sv
test/iso_date_stream_parser_unit_test.sv
